[design/rtcdc_pkg.sv]
// Shared widths, codes and handshake types for the RTC drift calibration block.
// No dependencies; imported by rtcdc_div and rtc_drift_calibration.
package rtcdc_pkg;

  localparam int TIME_W    = 32;
  localparam int FRAC_BITS = 20;
  localparam int DVD_W     = TIME_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DVD_W);
  localparam int TRIM_W    = 9;
  localparam int STATUS_W  = 2;

  localparam logic [TRIM_W-1:0] TRIM_MAX = 9'd511;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 2'd0,
    ST_REJECTED = 2'd1,
    ST_EQUAL    = 2'd2
  } status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[design/rtcdc_div.sv]
// Restoring radix-2 divider: one quotient bit per cycle while busy.
// Depends on rtcdc_pkg for widths and the status struct.
module rtcdc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rtcdc_pkg::DVD_W-1:0] dividend,
  input  logic [rtcdc_pkg::TIME_W-1:0] divisor,
  output rtcdc_pkg::div_sts_t          sts,
  output logic [rtcdc_pkg::DVD_W-1:0] quotient
);
  import rtcdc_pkg::*;

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   trial_sub;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial     = {rem_r, dvd_r[DVD_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fits      = (trial >= {1'b0, dvs_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r;

endmodule

[design/rtc_drift_calibration.sv]
// RTC drift calibration: one item at a time. A rejected or equal-time item gives its
// result in the cycle after acceptance; an update item gets its result once the 52-step
// serial divider (one quotient bit per cycle) is done, and no new item is taken until the
// result has been accepted. in_ready is high only while idle with no result pending.
// Synchronous active-low reset: trim and last update time clear to zero, block idle.
// Depends on rtcdc_pkg and rtcdc_div.
module rtc_drift_calibration (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rtcdc_pkg::TIME_W-1:0]   in_reference_time,
  input  logic [rtcdc_pkg::TIME_W-1:0]   in_local_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rtcdc_pkg::TRIM_W-1:0]   out_trim_value,
  output logic [rtcdc_pkg::STATUS_W-1:0] out_status,
  output logic                           out_saturated
);
  import rtcdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [TRIM_W-1:0]   trim_r, trim_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [TIME_W-1:0]   ref_hold_r, ref_hold_nxt;
  logic                fast_r, fast_nxt;
  logic [TRIM_W-1:0]   o_trim_r, o_trim_nxt;
  logic [STATUS_W-1:0] o_status_r, o_status_nxt;
  logic                o_sat_r, o_sat_nxt;

  logic                in_acc;
  logic                rejected;
  logic                equal;
  logic                fast;
  logic [TIME_W-1:0]   diff;
  logic [TIME_W-1:0]   span;
  logic [DVD_W-1:0]    dividend;
  logic                div_start;
  div_sts_t            div_sts;
  logic [DVD_W-1:0]    delta;
  logic [TRIM_W-1:0]   headroom;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Decode the arriving item against the stored last update time.
  assign rejected = (last_r >= in_reference_time);
  assign equal    = (in_local_time == in_reference_time);
  assign fast     = (in_local_time > in_reference_time);
  assign diff     = fast ? (in_local_time - in_reference_time)
                         : (in_reference_time - in_local_time);
  assign span     = in_reference_time - last_r;
  // Scale the drift by 2^20 ahead of the divide; the product is exact in 52 bits.
  assign dividend = {diff, {FRAC_BITS{1'b0}}};

  assign div_start = in_acc && !rejected && !equal;

  rtcdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span),
    .sts      (div_sts),
    .quotient (delta)
  );

  assign headroom = TRIM_MAX - trim_r;

  always_comb begin
    state_nxt    = state_r;
    trim_nxt     = trim_r;
    last_nxt     = last_r;
    ref_hold_nxt = ref_hold_r;
    fast_nxt     = fast_r;
    o_trim_nxt   = o_trim_r;
    o_status_nxt = o_status_r;
    o_sat_nxt    = o_sat_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (rejected) begin
            // Hold trim and last update time; report the trim as is.
            o_trim_nxt   = trim_r;
            o_status_nxt = ST_REJECTED;
            o_sat_nxt    = 1'b0;
            state_nxt    = S_OUT;
          end else if (equal) begin
            // No drift: change nothing, not even the last update time.
            o_trim_nxt   = trim_r;
            o_status_nxt = ST_EQUAL;
            o_sat_nxt    = 1'b0;
            state_nxt    = S_OUT;
          end else begin
            ref_hold_nxt = in_reference_time;
            fast_nxt     = fast;
            state_nxt    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          // Apply the quotient with clamping at both ends of the trim range.
          if (fast_r) begin
            if (delta > DVD_W'(headroom)) begin
              trim_nxt  = TRIM_MAX;
              o_sat_nxt = 1'b1;
            end else begin
              trim_nxt  = trim_r + delta[TRIM_W-1:0];
              o_sat_nxt = 1'b0;
            end
          end else begin
            if (delta > DVD_W'(trim_r)) begin
              trim_nxt  = '0;
              o_sat_nxt = 1'b1;
            end else begin
              trim_nxt  = trim_r - delta[TRIM_W-1:0];
              o_sat_nxt = 1'b0;
            end
          end
          o_trim_nxt   = trim_nxt;
          o_status_nxt = ST_UPDATED;
          last_nxt     = ref_hold_r;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        // Hold the result until the sink takes it.
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      trim_r  <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      trim_r  <= trim_nxt;
      last_r  <= last_nxt;
    end
    ref_hold_r <= ref_hold_nxt;
    fast_r     <= fast_nxt;
    o_trim_r   <= o_trim_nxt;
    o_status_r <= o_status_nxt;
    o_sat_r    <= o_sat_nxt;
  end

  assign out_valid      = (state_r == S_OUT);
  assign out_trim_value = o_trim_r;
  assign out_status     = o_status_r;
  assign out_saturated  = o_sat_r;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_sat_only_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_status == ST_UPDATED))
    else $error("saturation flagged on a result that did not update the trim");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready)
    else $error("block not ready after the result was taken");
`endif

endmodule

[sim/rtc_drift_calibration_tb.sv]
// Self-checking testbench for rtc_drift_calibration: directed sync table, then random syncs.
// Predicts trim, status and clamp flag per item and checks each result in order.
// Depends on rtcdc_pkg and the rtc_drift_calibration RTL.
module rtc_drift_calibration_tb;
  import rtcdc_pkg::*;

  // Expected result of one sync item.
  typedef struct packed {
    logic [TRIM_W-1:0] trim;
    status_t           status;
    logic              sat;
  } trim_res_t;

  // One row of the directed table; exp is used only where typed is set.
  typedef struct packed {
    logic [TIME_W-1:0] rt;
    logic [TIME_W-1:0] lt;
    logic              typed;
    trim_res_t         exp;
  } sync_row_t;

  localparam int N_RAND      = 1080;
  localparam int N_QUIET     = 150;   // final stretch with no idling on either side
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake before giving up
  localparam int DRAIN_WAIT  = 64;    // idle wait after the last result before the summary

  logic                clk               = 1'b0;
  logic                rst_n             = 1'b0;
  logic                in_valid          = 1'b0;
  logic                in_ready;
  logic [TIME_W-1:0]   in_reference_time = '0;
  logic [TIME_W-1:0]   in_local_time     = '0;
  logic                out_valid;
  logic                out_ready         = 1'b0;
  logic [TRIM_W-1:0]   out_trim_value;
  logic [STATUS_W-1:0] out_status;
  logic                out_saturated;

  // Predictor state: mirrors the trim register and the last accepted sync time.
  logic [TRIM_W-1:0]   mdl_trim      = '0;
  logic [TIME_W-1:0]   mdl_last_sync = '0;

  trim_res_t trim_expect_q[$];
  sync_row_t sync_table[$];

  int  mismatches  = 0;
  int  n_sent      = 0;
  int  n_updated   = 0;
  int  n_clamped   = 0;
  int  n_rejected  = 0;
  int  n_equal     = 0;
  int  idle_cycles = 0;
  int  rx_hold     = 0;
  bit  tx_idle_on  = 1'b0;
  bit  rx_idle_on  = 1'b0;

  rtc_drift_calibration DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_reference_time (in_reference_time),
    .in_local_time     (in_local_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trim_value    (out_trim_value),
    .out_status        (out_status),
    .out_saturated     (out_saturated)
  );

  always #5 clk = ~clk;

  // Work out the result of one sync item and advance the predictor state.
  // Reject first (reference not later than the last sync), then equal times,
  // else scale the drift by 2^20 over the elapsed span and clamp the trim.
  function automatic trim_res_t predict_trim(input logic [TIME_W-1:0] rt,
                                             input logic [TIME_W-1:0] lt);
    trim_res_t         res;
    logic              fast;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] span;
    logic [DVD_W-1:0]  delta;
    res.trim   = mdl_trim;
    res.status = ST_UPDATED;
    res.sat    = 1'b0;
    if (rt <= mdl_last_sync) begin
      res.status = ST_REJECTED;
    end else if (lt == rt) begin
      res.status = ST_EQUAL;
    end else begin
      fast  = lt > rt;
      diff  = fast ? lt - rt : rt - lt;
      span  = rt - mdl_last_sync;
      delta = {diff, {FRAC_BITS{1'b0}}} / {{FRAC_BITS{1'b0}}, span};
      if (fast) begin
        if (delta > {{(DVD_W-TRIM_W){1'b0}}, TRIM_MAX - mdl_trim}) begin
          res.trim = TRIM_MAX;
          res.sat  = 1'b1;
        end else begin
          res.trim = mdl_trim + delta[TRIM_W-1:0];
        end
      end else begin
        if (delta > {{(DVD_W-TRIM_W){1'b0}}, mdl_trim}) begin
          res.trim = '0;
          res.sat  = 1'b1;
        end else begin
          res.trim = mdl_trim - delta[TRIM_W-1:0];
        end
      end
      mdl_trim      = res.trim;
      mdl_last_sync = rt;
    end
    return res;
  endfunction

  task automatic add_row(input logic [TIME_W-1:0] rt, input logic [TIME_W-1:0] lt,
                         input logic typed, input logic [TRIM_W-1:0] trim,
                         input status_t status, input logic sat);
    sync_row_t row;
    row.rt         = rt;
    row.lt         = lt;
    row.typed      = typed;
    row.exp.trim   = trim;
    row.exp.status = status;
    row.exp.sat    = sat;
    sync_table.push_back(row);
  endtask

  // Present one item and hold it until accepted, then queue its expectation.
  // Valid stays high on return; the caller drops it only when it idles.
  task automatic send_sync(input logic [TIME_W-1:0] rt, input logic [TIME_W-1:0] lt,
                           input logic typed, input trim_res_t typed_res);
    trim_res_t pred;
    in_valid          <= 1'b1;
    in_reference_time <= rt;
    in_local_time     <= lt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_trim(rt, lt);
    trim_expect_q.push_back(typed ? typed_res : pred);
    n_sent++;
  endtask

  // Sender side idling: a random gap, or a full drain of pending results.
  task automatic tx_idle(input bit drain);
    if (drain) begin
      in_valid <= 1'b0;
      while (trim_expect_q.size() != 0) @(posedge clk);
    end else if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic report(input string field, input int exp_v, input int act_v);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
    mismatches++;
  endtask

  // Receiver: stall now and then while idling is on, else stay ready.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_hold   <= $urandom_range(1, 13) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    trim_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (trim_expect_q.size() == 0) begin
        $display("%0t: unexpected result: trim=%0d status=%0d saturated=%0d",
                 $time, out_trim_value, out_status, out_saturated);
        mismatches++;
      end else begin
        e = trim_expect_q.pop_front();
        if (out_trim_value !== e.trim)   report("trim_value", e.trim, out_trim_value);
        if (out_status !== e.status)     report("status", e.status, out_status);
        if (out_saturated !== e.sat)     report("saturated", e.sat, out_saturated);
        case (e.status)
          ST_UPDATED: begin
            n_updated++;
            if (e.sat) n_clamped++;
          end
          ST_REJECTED: n_rejected++;
          default:     n_equal++;
        endcase
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    trim_res_t         none_res;
    logic [TIME_W-1:0] head;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] rt;
    logic [TIME_W-1:0] lt;
    int                kind;
    int                shift;
    bit                fast;
    none_res = '0;

    // Directed table. Times are absolute; the comments track the sync state.
    // Right after reset: trim 0, last sync 0, so reference 0 is not later.
    add_row(32'd0,        32'd0,          1, 9'd0,   ST_REJECTED, 0);
    add_row(32'd0,        32'hFFFF_FFFF,  1, 9'd0,   ST_REJECTED, 0);
    add_row(32'd1,        32'd1,          1, 9'd0,   ST_EQUAL,    0);
    add_row(32'd100,      32'd100,        1, 9'd0,   ST_EQUAL,    0);
    // One second fast over 1000 s: delta 1048, clamp high; last sync 1000.
    add_row(32'd1000,     32'd1001,       1, 9'd511, ST_UPDATED,  1);
    add_row(32'd1000,     32'd5,          1, 9'd511, ST_REJECTED, 0);
    // One second slow over 1000 s: clamp low; last sync 2000.
    add_row(32'd2000,     32'd1999,       1, 9'd0,   ST_UPDATED,  1);
    // Span 2^20 and drift 511: land exactly on each bound, no clamp flag; then drift 1 adds 1.
    add_row(32'd1050576,  32'd1051087,    1, 9'd511, ST_UPDATED,  0);
    add_row(32'd2099152,  32'd2098641,    1, 9'd0,   ST_UPDATED,  0);
    add_row(32'd3147728,  32'd3147729,    1, 9'd1,   ST_UPDATED,  0);
    // Delta rounds down to zero over a 2^21 span.
    add_row(32'd5244880,  32'd5244881,    1, 9'd1,   ST_UPDATED,  0);
    // Local time at its extremes over a one-second span.
    add_row(32'd5244881,  32'd0,          1, 9'd0,   ST_UPDATED,  1);
    add_row(32'd5244882,  32'hFFFF_FFFF,  1, 9'd511, ST_UPDATED,  1);
    // Same reference as last sync and equal times: rejection wins.
    add_row(32'd5244882,  32'd5244882,    1, 9'd511, ST_REJECTED, 0);
    add_row(32'd5244883,  32'd5244883,    1, 9'd511, ST_EQUAL,    0);
    // Mid-range drifts, checked against the predictor.
    add_row(32'd6244882,  32'd6244782,    0, 9'd0,   ST_UPDATED,  0);
    add_row(32'd6248978,  32'd6248981,    0, 9'd0,   ST_UPDATED,  0);
    add_row(32'd6348978,  32'd6348900,    0, 9'd0,   ST_UPDATED,  0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (sync_table[k]) begin
      send_sync(sync_table[k].rt, sync_table[k].lt, sync_table[k].typed, sync_table[k].exp);
      tx_idle(k == 5);
    end
    tx_idle(1'b1);

    // Random part: mostly well-formed syncs moving forward in time, with
    // rejected, equal-time and wild-drift items mixed in. Rare big jumps
    // push the last sync time up through the upper bits.
    for (int i = 0; i < N_RAND; i++) begin
      if (i >= N_RAND - N_QUIET) begin
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
      end else if (i % 50 == 0) begin
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on <= $urandom_range(0, 2) != 0;
      end
      head = 32'hFFFF_FFFF - mdl_last_sync;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        if (kind < 3) span = $urandom_range(1, (head / 8 > 0) ? head / 8 : 1);
        else          span = $urandom_range(1, 1 << $urandom_range(8, 20));
        if (span > head) span = head;
        rt    = mdl_last_sync + span;
        shift = $urandom_range(9, 14);
        diff  = $urandom_range(1, ((span >> shift) > 1) ? (span >> shift) : 1);
        fast  = $urandom_range(0, 1);
        if (fast) lt = (diff > 32'hFFFF_FFFF - rt) ? 32'hFFFF_FFFF : rt + diff;
        else      lt = (diff > rt) ? 32'd0 : rt - diff;
      end else if (kind < 85) begin
        rt = $urandom_range(0, mdl_last_sync);
        lt = $urandom;
      end else if (kind < 93) begin
        span = $urandom_range(1, 4096);
        rt   = mdl_last_sync + ((span > head) ? head : span);
        lt   = rt;
      end else begin
        span = $urandom_range(1, 1 << 16);
        rt   = mdl_last_sync + ((span > head) ? head : span);
        lt   = $urandom;
      end
      send_sync(rt, lt, 1'b0, none_res);
      // Drain now and then so the sender waits on an empty pipeline.
      tx_idle(i == 300 || (i < N_RAND - N_QUIET && $urandom_range(0, 49) == 0));
    end

    // Close with the reference time at all ones, then once more to reject it.
    send_sync(32'hFFFF_FFFF, $urandom, 1'b0, none_res);
    send_sync(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none_res);
    in_valid <= 1'b0;

    while (trim_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d sync items: %0d trim updates (%0d clamped), %0d rejected, %0d equal.",
             n_sent, n_updated, n_clamped, n_rejected, n_equal);
    $display("Last accepted sync time 0x%08h, final trim %0d, %0d mismatches.",
             mdl_last_sync, mdl_trim, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
design/rtcdc_pkg.sv
design/rtcdc_div.sv
design/rtc_drift_calibration.sv
sim/rtc_drift_calibration_tb.sv
